### hdl/fpa_pkg.sv
// package: opcodes, pipeline control struct and default sizes for the fixed-point alu
package fpa_pkg;

    localparam int FRACTION_BITS_DEF = 8;
    localparam int WORD_WIDTH_DEF    = 32;
    localparam int FIELD_WIDTH       = 32;
    localparam int MODE_WIDTH        = 4;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_ADD     = 4'd0,
        MODE_SUB     = 4'd1,
        MODE_MUL     = 4'd2,
        MODE_DIV     = 4'd3,
        MODE_GT      = 4'd4,
        MODE_LT      = 4'd5,
        MODE_GE      = 4'd6,
        MODE_LE      = 4'd7,
        MODE_EQ      = 4'd8,
        MODE_NE      = 4'd9,
        MODE_INC     = 4'd10,
        MODE_DEC     = 4'd11,
        MODE_MAX     = 4'd12,
        MODE_MIN     = 4'd13,
        MODE_TOINT   = 4'd14,
        MODE_FROMINT = 4'd15
    } t_mode;

    typedef struct packed {
        logic  valid;
        t_mode mode;
        logic  cmp;
        logic  dz;
        logic  neg;
    } t_ctl;

endpackage

### hdl/fixed_point_alu_q24_8.sv
// top level: pipelined signed fixed-point alu
// usage
//   input channel: i_valid / o_stall with beat fields i_mode, i_operand_a, i_operand_b;
//   a beat is taken at a rising edge with i_valid high and o_stall low
//   output channel: o_valid / i_stall with o_result_value, o_compare_true,
//   o_divide_by_zero; one result beat for every input beat, in order
//   path: every opcode passes the entry register, then one divider stage per
//   quotient bit, then the output register; the divider sets the depth
//   throughput: one beat per cycle while the output is not stalled; every opcode travels the same pipeline
//   stall: the whole pipeline holds while the output beat waits; o_stall is
//   high only then, so the output register is the only point of backpressure
//   reset: synchronous, active low; all valid bits clear, no beat is in flight
//   words narrower than 32 bits use the low bits of each operand and the
//   result is sign-extended to 32 bits
module fixed_point_alu_q24_8 import fpa_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int WORD_WIDTH    = WORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [MODE_WIDTH-1:0]         i_mode,
    input  logic signed [FIELD_WIDTH-1:0] i_operand_a,
    input  logic signed [FIELD_WIDTH-1:0] i_operand_b,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [FIELD_WIDTH-1:0] o_result_value,
    output logic                          o_compare_true,
    output logic                          o_divide_by_zero
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int NW = W + F;

    // pipeline advance: output register empty or being taken
    logic adv;

    // entry decode
    t_mode               mode;
    logic signed [W-1:0] a_w;
    logic signed [W-1:0] b_w;
    logic signed [2*W-1:0] prod;
    logic [W-1:0]        abs_a;
    logic [W-1:0]        abs_b;
    logic [W-1:0]        n_res;
    logic                n_cmp;
    logic                n_dz;

    // stage 0: decoded item, full product and divide operands
    t_ctl                r_ctl0;
    logic [W-1:0]        r_res0;
    logic signed [2*W-1:0] r_prod0;
    logic [NW-1:0]       r_num0;
    logic [W-1:0]        r_den0;
    logic [W-1:0]        res0_fix;

    // divider chain
    t_ctl                ctl_s [0:NW];
    logic [W-1:0]        res_s [0:NW];
    logic [W-1:0]        rem_s [0:NW];
    logic [NW-1:0]       qn_s  [0:NW];
    logic [W-1:0]        den_s [0:NW];

    // output register
    logic                r_out_valid;
    logic [W-1:0]        r_out_res;
    logic                r_out_cmp;
    logic                r_out_dz;
    logic [W-1:0]        quo;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    assign mode = t_mode'(i_mode);
    assign a_w  = i_operand_a[W-1:0];
    assign b_w  = i_operand_b[W-1:0];
    assign prod = a_w * b_w;
    assign abs_a = a_w[W-1] ? W'(-a_w) : W'(a_w);
    assign abs_b = b_w[W-1] ? W'(-b_w) : W'(b_w);

    // entry results for all opcodes but multiply and divide, comparisons and the divide-by-zero flag
    always_comb begin
        n_res = '0;
        n_cmp = 1'b0;
        n_dz  = 1'b0;
        unique case (mode)
            MODE_ADD:     n_res = W'(a_w + b_w);
            MODE_SUB:     n_res = W'(a_w - b_w);
            MODE_MUL:     n_res = '0;
            MODE_DIV:     n_dz  = (b_w == '0);
            MODE_GT:      n_cmp = (a_w > b_w);
            MODE_LT:      n_cmp = (a_w < b_w);
            MODE_GE:      n_cmp = (a_w >= b_w);
            MODE_LE:      n_cmp = (a_w <= b_w);
            MODE_EQ:      n_cmp = (a_w == b_w);
            MODE_NE:      n_cmp = (a_w != b_w);
            MODE_INC:     n_res = W'(a_w + W'(1));
            MODE_DEC:     n_res = W'(a_w - W'(1));
            MODE_MAX:     n_res = (a_w > b_w) ? a_w : b_w;
            MODE_MIN:     n_res = (a_w < b_w) ? a_w : b_w;
            MODE_TOINT:   n_res = W'(a_w >>> F);
            MODE_FROMINT: n_res = W'(a_w << F);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0.valid <= 1'b0;
        end else if (adv) begin
            r_ctl0.valid <= i_valid;
            r_ctl0.mode  <= mode;
            r_ctl0.cmp   <= n_cmp;
            r_ctl0.dz    <= n_dz;
            r_ctl0.neg   <= a_w[W-1] ^ b_w[W-1];
            r_res0       <= n_res;
            r_prod0      <= prod;
            r_num0       <= {abs_a, F'(0)};
            r_den0       <= abs_b;
        end
    end

    // product scaled back by the fraction bits and wrapped to the word
    assign res0_fix = (r_ctl0.mode == MODE_MUL) ? r_prod0[F+W-1:F] : r_res0;

    assign ctl_s[0] = r_ctl0;
    assign res_s[0] = res0_fix;
    assign rem_s[0] = '0;
    assign qn_s[0]  = r_num0;
    assign den_s[0] = r_den0;

    for (genvar k = 0; k < NW; k++) begin : g_div
        fpa_div_stage #(
            .W  (W),
            .NW (NW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_ctl   (ctl_s[k]),
            .i_res   (res_s[k]),
            .i_rem   (rem_s[k]),
            .i_qn    (qn_s[k]),
            .i_den   (den_s[k]),
            .o_ctl   (ctl_s[k+1]),
            .o_res   (res_s[k+1]),
            .o_rem   (rem_s[k+1]),
            .o_qn    (qn_s[k+1]),
            .o_den   (den_s[k+1])
        );
    end

    // quotient magnitude back to a signed word, truncated toward zero
    assign quo = ctl_s[NW].neg ? W'(-qn_s[NW][W-1:0]) : qn_s[NW][W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= ctl_s[NW].valid;
            r_out_cmp   <= ctl_s[NW].cmp;
            r_out_dz    <= ctl_s[NW].dz;
            if (ctl_s[NW].mode == MODE_DIV) begin
                r_out_res <= ctl_s[NW].dz ? '0 : quo;
            end else begin
                r_out_res <= res_s[NW];
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_value   = FIELD_WIDTH'($signed(r_out_res));
    assign o_compare_true   = r_out_cmp;
    assign o_divide_by_zero = r_out_dz;

endmodule

### hdl/fpa_div_stage.sv
// one restoring division step as a pipeline stage, carrying the item alongside
module fpa_div_stage import fpa_pkg::*; #(
    parameter int W  = WORD_WIDTH_DEF,
    parameter int NW = WORD_WIDTH_DEF + FRACTION_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [W-1:0]  i_res,
    input  logic [W-1:0]  i_rem,
    input  logic [NW-1:0] i_qn,
    input  logic [W-1:0]  i_den,
    output t_ctl          o_ctl,
    output logic [W-1:0]  o_res,
    output logic [W-1:0]  o_rem,
    output logic [NW-1:0] o_qn,
    output logic [W-1:0]  o_den
);

    logic [W:0]    trial;
    logic [W-1:0]  n_rem;
    logic [NW-1:0] n_qn;
    t_ctl          r_ctl;
    logic [W-1:0]  r_res;
    logic [W-1:0]  r_rem;
    logic [NW-1:0] r_qn;
    logic [W-1:0]  r_den;

    // partial remainder stays below the divisor, so the shifted value fits w bits
    always_comb begin
        trial = {i_rem, i_qn[NW-1]} - {1'b0, i_den};
        if (!trial[W]) begin
            n_rem = trial[W-1:0];
        end else begin
            n_rem = {i_rem[W-2:0], i_qn[NW-1]};
        end
        n_qn = {i_qn[NW-2:0], ~trial[W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
            r_res <= i_res;
            r_rem <= n_rem;
            r_qn  <= n_qn;
            r_den <= i_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_res = r_res;
    assign o_rem = r_rem;
    assign o_qn  = r_qn;
    assign o_den = r_den;

endmodule

### verif/fpa_checker.sv
// result checker: predicts each alu result from the accepted input beats and compares
`timescale 1ns / 1ps
module fpa_checker import fpa_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_in_stall,
    input  logic [MODE_WIDTH-1:0]         i_mode,
    input  logic signed [FIELD_WIDTH-1:0] i_operand_a,
    input  logic signed [FIELD_WIDTH-1:0] i_operand_b,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [FIELD_WIDTH-1:0] i_result_value,
    input  logic                          i_compare_true,
    input  logic                          i_divide_by_zero,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_results_seen
);
    localparam int FB = FRACTION_BITS_DEF;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        dz;
    } t_alu_result;

    t_alu_result expected_results[$];

    function automatic t_alu_result alu_predict(t_mode op, logic signed [31:0] a,
                                                logic signed [31:0] b);
        t_alu_result r;
        logic signed [63:0] wide;
        r = '0;
        case (op)
            MODE_ADD:     r.value = a + b;
            MODE_SUB:     r.value = a - b;
            MODE_MUL: begin
                wide = 64'(a) * 64'(b);
                r.value = 32'(wide >>> FB);
            end
            MODE_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    wide = (64'(a) <<< FB) / 64'(b);
                    r.value = 32'(wide);
                end
            end
            MODE_GT:      r.cmp = a > b;
            MODE_LT:      r.cmp = a < b;
            MODE_GE:      r.cmp = a >= b;
            MODE_LE:      r.cmp = a <= b;
            MODE_EQ:      r.cmp = a == b;
            MODE_NE:      r.cmp = a != b;
            MODE_INC:     r.value = a + 1;
            MODE_DEC:     r.value = a - 1;
            MODE_MAX:     r.value = (a > b) ? a : b;
            MODE_MIN:     r.value = (a < b) ? a : b;
            MODE_TOINT:   r.value = a >>> FB;
            MODE_FROMINT: r.value = a <<< FB;
            default:      r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("error: %s got %h expected %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results_seen = 0;
    end

    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall)
                expected_results.push_back(alu_predict(t_mode'(i_mode), i_operand_a,
                                                       i_operand_b));
            if (i_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", i_result_value, 'x);
                end else begin
                    want = expected_results.pop_front();
                    if (i_result_value !== want.value)
                        report_mismatch("result_value", i_result_value, want.value);
                    if (i_compare_true !== want.cmp)
                        report_mismatch("compare_true", i_compare_true, want.cmp);
                    if (i_divide_by_zero !== want.dz)
                        report_mismatch("divide_by_zero", i_divide_by_zero, want.dz);
                end
            end
            o_pending = expected_results.size();
        end
    end
endmodule

### verif/tb_top.sv
// testbench top: stimulus, backpressure and verdict for the fixed-point alu
`timescale 1ns / 1ps
module tb_top;
    import fpa_pkg::*;

    localparam int LATENCY     = WORD_WIDTH_DEF + FRACTION_BITS_DEF + 2;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [MODE_WIDTH-1:0] i_mode = '0;
    logic signed [FIELD_WIDTH-1:0] i_operand_a = '0;
    logic signed [FIELD_WIDTH-1:0] i_operand_b = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [FIELD_WIDTH-1:0] o_result_value;
    logic o_compare_true;
    logic o_divide_by_zero;

    int errors, pending, results_seen;
    int cycles = 0;
    int beats_sent = 0;
    // receiver holds off while this is set, giving a long stretch of backpressure
    logic hold_sink = 1'b0;
    logic stim_done = 1'b0;

    always #5 i_clk = ~i_clk;

    fixed_point_alu_q24_8 u_dut (.*);

    fpa_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_mode, .i_operand_a,
        .i_operand_b, .i_out_valid(o_valid), .i_out_stall(i_stall), .i_result_value(o_result_value),
        .i_compare_true(o_compare_true), .i_divide_by_zero(o_divide_by_zero),
        .o_errors(errors), .o_pending(pending), .o_results_seen(results_seen)
    );

    // mostly no gap, sometimes a short one, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // operand with a bias towards corners and small magnitudes
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 8)) - 4);
            3: return 32'($signed($urandom_range(0, 2048)) - 1024);
            4: return 32'($signed($urandom_range(0, 65536)) - 32768) << 8;
            default: return $urandom;
        endcase
    endfunction

    // one beat: present it and hold until taken
    task automatic send_beat(input t_mode op, input logic [31:0] a, input logic [31:0] b);
        i_valid <= 1'b1;
        i_mode <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // cycle limit guards against a hang
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("fixed_point_alu_q24_8: mismatch");
            $finish;
        end
    end

    // receiver stall pattern, with stretches of none and the long hold
    always @(posedge i_clk) begin
        if (hold_sink)
            i_stall <= 1'b1;
        else if (cycles % 2000 < 300)
            i_stall <= 1'b0;
        else if ($urandom_range(0, 39) == 0)
            i_stall <= 1'b1;
        else
            i_stall <= ($urandom_range(0, 3) == 0);
    end

    // long receiver hold-off counted in its own process
    initial begin
        wait (beats_sent >= 200);
        @(posedge i_clk);
        hold_sink <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_sink <= 1'b0;
    end

    initial begin
        logic [31:0] corners[6];
        corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h100};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every opcode once with mixed corners, then the special cases
        for (int m = 0; m < 16; m++)
            send_beat(t_mode'(m), corners[m % 6], corners[(m + 3) % 6]);
        send_beat(MODE_DIV, 32'h0000_0500, 32'h0);            // zero divisor
        send_beat(MODE_DIV, 32'h8000_0000, 32'hffff_ffff);    // quotient wraps
        send_beat(MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff);    // product wraps
        send_beat(MODE_DIV, 32'hffff_fd00, 32'h0000_0200);    // negative dividend, exact quotient
        send_beat(MODE_TOINT, 32'hffff_ff01, 32'h0);          // rounds toward minus infinity
        send_beat(MODE_MAX, 32'h0000_0300, 32'h0000_0300);    // equal operands
        send_beat(MODE_MIN, 32'hffff_ff00, 32'hffff_ff00);
        send_beat(MODE_EQ, 32'h8000_0000, 32'h8000_0000);
        idle_cycles(1);

        // random part; halfway the sender drains the pipe completely
        for (int n = 0; n < 850; n++) begin
            if (n == 425) begin
                i_valid <= 1'b0;
                wait (pending == 0);
                @(posedge i_clk);
            end
            send_beat(t_mode'($urandom_range(0, 15)),
                      ($urandom_range(0, 3) == 0) ? $urandom : pick_operand(),
                      ($urandom_range(0, 9) == 0) ? 32'h0 : pick_operand());
            idle_cycles(gap_len());
        end
        i_valid <= 1'b0;
        stim_done <= 1'b1;

        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d beats over all 16 opcodes, %0d results checked", beats_sent,
                 results_seen);
        $display("covered operand corners, zero divisors, wrap cases and long backpressure");
        if (errors == 0 && pending == 0)
            $display("fixed_point_alu_q24_8: match");
        else
            $display("fixed_point_alu_q24_8: mismatch");
        $finish;
    end
endmodule
